FILE: rtl/convex_hull_point_set_engine_unit_defines.svh
// Assertion macros for the convex hull engine checker.
`ifndef CONVEX_HULL_POINT_SET_ENGINE_UNIT_DEFINES_SVH
`define CONVEX_HULL_POINT_SET_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CHPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define CHPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/chps_pkg.sv
// Shared types, constants and helpers of the convex hull engine.
`timescale 1ns / 1ps
package chps_pkg;

  localparam int unsigned MAX_POINTS_DEF = 32;
  localparam int unsigned RESULT_CAP     = 32;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned AREA_W         = 33;
  localparam int unsigned ACC_W          = 40;
  localparam int unsigned IN_DATA_W      = 32;
  localparam int unsigned OUT_DATA_W     = 72;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_HULL   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    op_e    op;
    point_t pt;
  } cmd_t;

  // Order by x, then by y
  function automatic logic pt_less(point_t a, point_t b);
    pt_less = (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

endpackage

FILE: rtl/chps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module chps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/chps_front.sv
// Front end: accepts items, decodes the operation, queues commands.
`timescale 1ns / 1ps
module chps_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,  // item valid
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [15:0] x_coord, [31:16] y_coord
  input  logic [1:0]            s_axis_tuser,   // [1:0] operation
  output logic                  q_valid_o,
  output chps_pkg::cmd_t        q_item_o,
  input  logic                  q_pop_i
);
  import chps_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  cmd_t       in_cmd;

  // Decode the incoming item
  always_comb begin
    in_cmd.op   = op_e'(s_axis_tuser);
    in_cmd.pt.x = s_axis_tdata[15:0];
    in_cmd.pt.y = s_axis_tdata[31:16];
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign pop           = q_pop_i && q_valid_o;
  assign q_item_o      = slot_q[rd_ptr_q];

  // Queue pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

FILE: rtl/chps_back.sv
// Back end: point store, sort, monotone chain, area and result output.
`timescale 1ns / 1ps
module chps_back #(
  parameter int unsigned MAX_POINTS = chps_pkg::MAX_POINTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  chps_pkg::cmd_t        q_item_i,
  output logic                  q_pop_o,
  output logic                  m_axis_tvalid,  // result valid
  input  logic                  m_axis_tready,
  output logic [71:0]           m_axis_tdata,   // [15:0] hull_x, [31:16] hull_y,
                                                // [64:32] twice_area, rest zero
  output logic [1:0]            m_axis_tuser,   // [1:0] status
  output logic                  m_axis_tlast    // last
);
  import chps_pkg::*;

  localparam int unsigned CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W    = $clog2(MAX_POINTS);
  localparam int unsigned SK_DEPTH = 2 * MAX_POINTS;
  localparam int unsigned SK_W     = $clog2(SK_DEPTH + 1);
  localparam int unsigned SKI_W    = $clog2(SK_DEPTH);
  localparam int unsigned EMIT_CAP = (RESULT_CAP < SK_DEPTH) ? RESULT_CAP : SK_DEPTH;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_PUT   = 15'h0002,
    S_REM   = 15'h0004,
    S_SORT  = 15'h0008,
    S_H_RD  = 15'h0010,
    S_H_LD  = 15'h0020,
    S_H_CHK = 15'h0040,
    S_H_CMP = 15'h0080,
    S_H_REF = 15'h0100,
    S_A_RD  = 15'h0200,
    S_A_LD  = 15'h0400,
    S_A_MUL = 15'h0800,
    S_A_ACC = 15'h1000,
    S_E_RD  = 15'h2000,
    S_E_LD  = 15'h4000
  } state_e;

  state_e state_q, state_d;

  // Control registers
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rd_i_q, rd_i_d;
  logic             rd_v_q, rd_v_d;
  logic [CNT_W-1:0] w_q, w_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             have_prev_q, have_prev_d;
  logic             have_best_q, have_best_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic             upper_q, upper_d;
  logic [SK_W-1:0]  k_q, k_d;
  logic [SK_W-1:0]  lim_q, lim_d;
  logic [SK_W-1:0]  j_q, j_d;
  logic [SK_W-1:0]  e_q, e_d;
  logic             wrap_q, wrap_d;
  logic             out_valid_q;

  // Payload registers
  point_t                    tgt_q, tgt_d;
  point_t                    prev_q, prev_d;
  point_t                    best_q, best_d;
  point_t                    first_q, first_d;
  point_t                    a_q, a_d, b_q, b_d, p_q, p_d;
  logic signed [33:0]        t1_q, t1_d, t2_q, t2_d;
  logic signed [31:0]        m1_q, m1_d, m2_q, m2_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [AREA_W-1:0]         area_q, area_d;
  point_t                    res_pt_q, res_pt_d;
  status_e                   res_st_q, res_st_d;
  point_t                    out_pt_q;
  logic [AREA_W-1:0]         out_area_q;
  status_e                   out_st_q;
  logic                      out_last_q;

  // Output load
  logic              out_free, out_ld, out_last;
  point_t            out_pt;
  logic [AREA_W-1:0] out_area;
  status_e           out_st;

  // Memory ports
  logic             st_we, st_re, so_we, so_re, sk_we, sk_re;
  logic [IDX_W-1:0] st_waddr, st_raddr, so_waddr, so_raddr;
  logic [SKI_W-1:0] sk_waddr, sk_raddr;
  point_t           st_wdata, so_wdata, sk_wdata;
  logic [31:0]      st_rdata, so_rdata, sk_rdata;

  // Datapath helpers
  logic signed [16:0]       dx1, dy1, dx2, dy2;
  logic signed [34:0]       tdiff;
  logic                     turn_le;
  logic [SK_W-1:0]          h_cnt, emit_cnt;
  logic signed [ACC_W-1:0]  acc_abs;
  point_t                   cand;

  chps_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .re_i(st_re), .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  chps_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_sorted (
    .clk_i, .we_i(so_we), .waddr_i(so_waddr), .wdata_i(so_wdata),
    .re_i(so_re), .raddr_i(so_raddr), .rdata_o(so_rdata)
  );

  chps_ram #(.WIDTH(32), .DEPTH(SK_DEPTH)) u_stack (
    .clk_i, .we_i(sk_we), .waddr_i(sk_waddr), .wdata_i(sk_wdata),
    .re_i(sk_re), .raddr_i(sk_raddr), .rdata_o(sk_rdata)
  );

  // Orientation test and area helpers
  always_comb begin
    dx1      = $signed({b_q.x[15], b_q.x}) - $signed({a_q.x[15], a_q.x});
    dy1      = $signed({b_q.y[15], b_q.y}) - $signed({a_q.y[15], a_q.y});
    dx2      = $signed({p_q.x[15], p_q.x}) - $signed({a_q.x[15], a_q.x});
    dy2      = $signed({p_q.y[15], p_q.y}) - $signed({a_q.y[15], a_q.y});
    tdiff    = $signed({t1_q[33], t1_q}) - $signed({t2_q[33], t2_q});
    turn_le  = tdiff[34] || (tdiff == '0);
    h_cnt    = k_q - SK_W'(1);
    emit_cnt = (h_cnt > SK_W'(EMIT_CAP)) ? SK_W'(EMIT_CAP) : h_cnt;
    acc_abs  = acc_q[ACC_W-1] ? -acc_q : acc_q;
    cand     = point_t'(st_rdata);
  end

  assign out_free = !out_valid_q || m_axis_tready;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_i_d      = rd_i_q;
    rd_v_d      = rd_v_q;
    w_d         = w_q;
    n_d         = n_q;
    have_prev_d = have_prev_q;
    have_best_d = have_best_q;
    i_d         = i_q;
    upper_d     = upper_q;
    k_d         = k_q;
    lim_d       = lim_q;
    j_d         = j_q;
    e_d         = e_q;
    wrap_d      = wrap_q;
    tgt_d       = tgt_q;
    prev_d      = prev_q;
    best_d      = best_q;
    first_d     = first_q;
    a_d         = a_q;
    b_d         = b_q;
    p_d         = p_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    m1_d        = m1_q;
    m2_d        = m2_q;
    acc_d       = acc_q;
    area_d      = area_q;
    res_pt_d    = res_pt_q;
    res_st_d    = res_st_q;
    q_pop_o     = 1'b0;
    out_ld      = 1'b0;
    out_pt      = '0;
    out_area    = '0;
    out_st      = ST_OK;
    out_last    = 1'b1;
    st_we       = 1'b0;
    st_waddr    = count_q[IDX_W-1:0];
    st_wdata    = q_item_i.pt;
    st_re       = 1'b0;
    st_raddr    = rd_i_q[IDX_W-1:0];
    so_we       = 1'b0;
    so_waddr    = n_q[IDX_W-1:0];
    so_wdata    = best_q;
    so_re       = 1'b0;
    so_raddr    = i_q;
    sk_we       = 1'b0;
    sk_waddr    = k_q[SKI_W-1:0];
    sk_wdata    = p_q;
    sk_re       = 1'b0;
    sk_raddr    = j_q[SKI_W-1:0];

    // Sequential scan of the point store, shared by remove and sort
    if ((state_q == S_REM) || (state_q == S_SORT)) begin
      if (rd_i_q < count_q) begin
        st_re  = 1'b1;
        rd_i_d = rd_i_q + CNT_W'(1);
        rd_v_d = 1'b1;
      end else begin
        rd_v_d = 1'b0;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          res_pt_d = '0;
          res_st_d = ST_OK;
          case (q_item_i.op)
            OP_CLEAR: begin
              count_d = '0;
              state_d = S_PUT;
            end
            OP_ADD: begin
              if (count_q >= CNT_W'(MAX_POINTS)) begin
                res_st_d = ST_FULL;
              end else begin
                st_we   = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
              state_d = S_PUT;
            end
            OP_REMOVE: begin
              tgt_d   = q_item_i.pt;
              rd_i_d  = '0;
              rd_v_d  = 1'b0;
              w_d     = '0;
              state_d = S_REM;
            end
            OP_HULL: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_PUT;
              end else begin
                n_d         = '0;
                have_prev_d = 1'b0;
                have_best_d = 1'b0;
                rd_i_d      = '0;
                rd_v_d      = 1'b0;
                state_d     = S_SORT;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // Single result
      S_PUT: begin
        if (out_free) begin
          out_ld  = 1'b1;
          out_pt  = res_pt_q;
          out_st  = res_st_q;
          state_d = S_IDLE;
        end
      end

      // Compact the store, dropping every copy of the target
      S_REM: begin
        if (rd_v_q && (cand != tgt_q)) begin
          st_we    = 1'b1;
          st_waddr = w_q[IDX_W-1:0];
          st_wdata = cand;
          w_d      = w_q + CNT_W'(1);
        end
        if ((rd_i_q == count_q) && !rd_v_q) begin
          if (w_q == count_q) begin
            res_st_d = ST_NOT_FOUND;
          end else begin
            count_d = w_q;
          end
          state_d = S_PUT;
        end
      end

      // Selection sort: each pass finds the least point above the previous one
      S_SORT: begin
        if (rd_v_q && (!have_prev_q || pt_less(prev_q, cand)) &&
            (!have_best_q || pt_less(cand, best_q))) begin
          best_d      = cand;
          have_best_d = 1'b1;
        end
        if ((rd_i_q == count_q) && !rd_v_q) begin
          if (have_best_q) begin
            so_we       = 1'b1;
            if (n_q == '0) begin
              first_d = best_q;
            end
            n_d         = n_q + CNT_W'(1);
            prev_d      = best_q;
            have_prev_d = 1'b1;
            have_best_d = 1'b0;
            rd_i_d      = '0;
          end else if (n_q == CNT_W'(1)) begin
            res_pt_d = first_q;
            state_d  = S_PUT;
          end else begin
            k_d     = '0;
            lim_d   = SK_W'(2);
            i_d     = '0;
            upper_d = 1'b0;
            state_d = S_H_RD;
          end
        end
      end

      S_H_RD: begin
        so_re   = 1'b1;
        state_d = S_H_LD;
      end

      S_H_LD: begin
        p_d     = point_t'(so_rdata);
        state_d = S_H_CHK;
      end

      S_H_CHK, S_H_CMP: begin
        if ((state_q == S_H_CHK) && (k_q >= lim_q)) begin
          t1_d    = dx1 * dy2;
          t2_d    = dy1 * dx2;
          state_d = S_H_CMP;
        end else if ((state_q == S_H_CMP) && turn_le) begin
          // Pop; refill the second entry from the stack memory
          k_d = k_q - SK_W'(1);
          b_d = a_q;
          if (k_q >= SK_W'(3)) begin
            sk_re    = 1'b1;
            sk_raddr = SKI_W'(k_q - SK_W'(3));
            state_d  = S_H_REF;
          end else begin
            state_d = S_H_CHK;
          end
        end else begin
          // Push and step to the next sorted point
          sk_we = 1'b1;
          a_d   = b_q;
          b_d   = p_q;
          k_d   = k_q + SK_W'(1);
          if (!upper_q) begin
            if (CNT_W'(i_q) == (n_q - CNT_W'(1))) begin
              upper_d = 1'b1;
              lim_d   = k_q + SK_W'(2);
              i_d     = IDX_W'(n_q - CNT_W'(2));
            end else begin
              i_d = i_q + IDX_W'(1);
            end
            state_d = S_H_RD;
          end else if (i_q == '0) begin
            j_d     = '0;
            acc_d   = '0;
            wrap_d  = 1'b0;
            state_d = S_A_RD;
          end else begin
            i_d     = i_q - IDX_W'(1);
            state_d = S_H_RD;
          end
        end
      end

      S_H_REF: begin
        a_d     = point_t'(sk_rdata);
        state_d = S_H_CHK;
      end

      // Shoelace sum over the hull: a holds the first vertex, b the previous
      S_A_RD: begin
        sk_re   = 1'b1;
        state_d = S_A_LD;
      end

      S_A_LD: begin
        if (j_q == '0) begin
          a_d     = point_t'(sk_rdata);
          b_d     = point_t'(sk_rdata);
          j_d     = SK_W'(1);
          state_d = S_A_RD;
        end else begin
          p_d     = point_t'(sk_rdata);
          state_d = S_A_MUL;
        end
      end

      S_A_MUL: begin
        m1_d    = b_q.x * p_q.y;
        m2_d    = p_q.x * b_q.y;
        state_d = S_A_ACC;
      end

      S_A_ACC: begin
        acc_d = acc_q + ACC_W'(m1_q) - ACC_W'(m2_q);
        b_d   = p_q;
        if (wrap_q) begin
          e_d     = '0;
          state_d = S_E_RD;
        end else if ((j_q + SK_W'(1)) == h_cnt) begin
          p_d     = a_q;
          wrap_d  = 1'b1;
          state_d = S_A_MUL;
        end else begin
          j_d     = j_q + SK_W'(1);
          state_d = S_A_RD;
        end
      end

      // Vertex emission
      S_E_RD: begin
        sk_re    = 1'b1;
        sk_raddr = e_q[SKI_W-1:0];
        area_d   = acc_abs[AREA_W-1:0];
        state_d  = S_E_LD;
      end

      S_E_LD: begin
        if (out_free) begin
          out_ld   = 1'b1;
          out_pt   = point_t'(sk_rdata);
          out_area = area_q;
          out_last = (e_q == (emit_cnt - SK_W'(1)));
          if (out_last) begin
            state_d = S_IDLE;
          end else begin
            e_d     = e_q + SK_W'(1);
            state_d = S_E_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_i_q      <= '0;
      rd_v_q      <= 1'b0;
      w_q         <= '0;
      n_q         <= '0;
      have_prev_q <= 1'b0;
      have_best_q <= 1'b0;
      i_q         <= '0;
      upper_q     <= 1'b0;
      k_q         <= '0;
      lim_q       <= '0;
      j_q         <= '0;
      e_q         <= '0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_i_q      <= rd_i_d;
      rd_v_q      <= rd_v_d;
      w_q         <= w_d;
      n_q         <= n_d;
      have_prev_q <= have_prev_d;
      have_best_q <= have_best_d;
      i_q         <= i_d;
      upper_q     <= upper_d;
      k_q         <= k_d;
      lim_q       <= lim_d;
      j_q         <= j_d;
      e_q         <= e_d;
      wrap_q      <= wrap_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    tgt_q    <= tgt_d;
    prev_q   <= prev_d;
    best_q   <= best_d;
    first_q  <= first_d;
    a_q      <= a_d;
    b_q      <= b_d;
    p_q      <= p_d;
    t1_q     <= t1_d;
    t2_q     <= t2_d;
    m1_q     <= m1_d;
    m2_q     <= m2_d;
    acc_q    <= acc_d;
    area_q   <= area_d;
    res_pt_q <= res_pt_d;
    res_st_q <= res_st_d;
    if (out_ld) begin
      out_pt_q   <= out_pt;
      out_area_q <= out_area;
      out_st_q   <= out_st;
      out_last_q <= out_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_area_q, out_pt_q.y, out_pt_q.x};
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/convex_hull_point_set_engine_unit.sv
// Top level of the convex hull point-set engine.
// Holds up to MAX_POINTS 2-D points and computes their convex hull by the
// monotone chain. Remove scans the point store through its one read port. A
// hull compute runs a selection sort that scans the store once per distinct
// point and once more to finish, then runs the orientation tests of the chain,
// sums the area over the hull vertices and emits the vertices. No clearing pass
// follows reset. Items are queued two deep, and one finished result is held in
// the output register while work continues.
`timescale 1ns / 1ps
module convex_hull_point_set_engine_unit #(
  parameter int unsigned MAX_POINTS = chps_pkg::MAX_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] x_coord, [31:16] y_coord
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [15:0] hull_x, [31:16] hull_y,
                                      // [64:32] twice_area, [71:65] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // last
);
  import chps_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_item;

  chps_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  chps_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

endmodule

FILE: rtl/chps_checker.sv
// Port-level checker for the convex hull engine, bound to the top level.
`timescale 1ns / 1ps
`include "convex_hull_point_set_engine_unit_defines.svh"
module chps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import chps_pkg::*;

  // A stalled result holds
  `CHPS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  // Status results are single and close their item
  `CHPS_ASSERT_IMP(a_status_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tlast)
  // Status results carry no vertex and no area
  `CHPS_ASSERT_IMP(a_status_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0)

endmodule

bind convex_hull_point_set_engine_unit chps_checker u_chps_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
  .m_axis_tlast(m_axis_tlast)
);
